FILE: rtl/pgpc_pkg.sv
// shared constants, codes and fixed-point helpers for the polar go-to-pose controller
package pgpc_pkg;

  localparam int TICK_MS          = 100;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int CW     = 36;   // cordic x/y width
  localparam int ZW     = 25;   // cordic angle width, q.20
  localparam int NUM_W  = 56;   // dividend width of the serial divider
  localparam int REM_W  = 23;   // remainder / divisor width
  localparam int CNT_W  = 6;    // bit counter for sqrt and divider
  localparam int RAD_W  = 50;   // radicand width
  localparam int ROOT_W = 25;

  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NUM_W - 1);

  localparam logic signed [17:0] PI_Q12      = 18'sd12868;
  localparam logic signed [17:0] HALF_PI_Q12 = 18'sd6434;
  localparam logic signed [17:0] TWO_PI_Q12  = 18'sd25736;
  localparam logic signed [ZW-1:0] HALF_PI_Q20 = 25'sd1647099;
  localparam logic [ROOT_W-1:0] NEAR_Q12 = 25'd410;
  localparam logic signed [CW-1:0] CORDIC_INV_GAIN = 36'sd652032874;

  localparam logic [REM_W-1:0] DIV_XY = REM_W'(1000 * 4096);
  localparam logic [REM_W-1:0] DIV_H  = REM_W'(1000);
  localparam logic [REM_W-1:0] DIV_E  = REM_W'(1024000);

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef enum logic [1:0] {
    TS_WAITING   = 2'd0,
    TS_RUNNING   = 2'd1,
    TS_COMPLETED = 2'd2
  } task_status_t;

  typedef enum logic [2:0] {
    REG_GOAL_X       = 3'd0,
    REG_GOAL_Y       = 3'd1,
    REG_GOAL_HEADING = 3'd2,
    REG_GAIN_RHO     = 3'd3,
    REG_GAIN_ALPHA   = 3'd4,
    REG_GAIN_BETA    = 3'd5,
    REG_SPEED_LIMIT  = 3'd6,
    REG_ENERGY       = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_X = 2'd0,
    OP_Y = 2'd1,
    OP_H = 2'd2,
    OP_E = 2'd3
  } int_op_t;

  // atan(2^-i) in q.20
  function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0:  r = 25'sd823550;
      5'd1:  r = 25'sd486170;
      5'd2:  r = 25'sd256879;
      5'd3:  r = 25'sd130396;
      5'd4:  r = 25'sd65451;
      5'd5:  r = 25'sd32757;
      5'd6:  r = 25'sd16383;
      5'd7:  r = 25'sd8192;
      5'd8:  r = 25'sd4096;
      5'd9:  r = 25'sd2048;
      5'd10: r = 25'sd1024;
      5'd11: r = 25'sd512;
      5'd12: r = 25'sd256;
      5'd13: r = 25'sd128;
      5'd14: r = 25'sd64;
      5'd15: r = 25'sd32;
      5'd16: r = 25'sd16;
      5'd17: r = 25'sd8;
      5'd18: r = 25'sd4;
      5'd19: r = 25'sd2;
      5'd20: r = 25'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [17:0] sx15(input logic signed [14:0] a);
    return $signed({{3{a[14]}}, a});
  endfunction

  // wrap into (-pi, pi], valid for |a| < 2*(2 pi)
  function automatic logic signed [14:0] wrap_q12(input logic signed [17:0] a);
    logic signed [17:0] r;
    r = a;
    if (r >= TWO_PI_Q12) r = r - TWO_PI_Q12;
    else if (r <= -TWO_PI_Q12) r = r + TWO_PI_Q12;
    if (r > PI_Q12) r = r - TWO_PI_Q12;
    else if (r <= -PI_Q12) r = r + TWO_PI_Q12;
    return r[14:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [57:0] a);
    logic signed [23:0] r;
    if (a > 58'sd8388607) r = 24'sh7FFFFF;
    else if (a < -58'sd8388608) r = 24'sh800000;
    else r = a[23:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [57:0] a);
    logic signed [15:0] r;
    if (a > 58'sd32767) r = 16'sh7FFF;
    else if (a < -58'sd32768) r = 16'sh8000;
    else r = a[15:0];
    return r;
  endfunction

endpackage

FILE: rtl/polar_goto_pose_controller_top.sv
// polar-coordinate go-to-pose controller with sequencer, shared multiplier and serial units
// restart, waiting and completed ticks go straight from idle to done and the output register;
//   a tick that reaches the goal first runs the squares, the square root and the near check
// throughput: one item at a time; the serial divider (4 passes of 56 bit steps), the
//   2-bit-per-cycle square root and the two cordic loops set the step time
// the output register holds a result while the next beat is accepted and worked on
// reset: synchronous, active high; status goes to waiting and registers to their defaults
module polar_goto_pose_controller_top
  import pgpc_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // pose_x[23:0], pose_y[47:24], pose_heading[62:48], zero pad
  input  logic         s_tuser,   // command
  output logic         m_tvalid,
  input  logic         m_tready,
  // linear_speed[23:0], turn_rate[39:24], next_x[63:40], next_y[87:64],
  // next_heading[103:88], energy_used[135:104], task_state[137:136], zero pad
  output logic [143:0] m_tdata,
  output logic         m_tuser,   // moved
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int IT_W = $clog2(CORDIC_STEPS);
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(CORDIC_STEPS - 1);

  typedef enum logic [18:0] {
    S_IDLE = 19'b0000000000000000001,
    S_SQX  = 19'b0000000000000000010,
    S_SQY  = 19'b0000000000000000100,
    S_SQS  = 19'b0000000000000001000,
    S_SQRT = 19'b0000000000000010000,
    S_NEAR = 19'b0000000000000100000,
    S_ATAN = 19'b0000000000001000000,
    S_ANG  = 19'b0000000000010000000,
    S_VMUL = 19'b0000000000100000000,
    S_VCAP = 19'b0000000001000000000,
    S_W1   = 19'b0000000010000000000,
    S_W2   = 19'b0000000100000000000,
    S_SIN  = 19'b0000001000000000000,
    S_SINF = 19'b0000010000000000000,
    S_MUL  = 19'b0000100000000000000,
    S_PREP = 19'b0001000000000000000,
    S_DIV  = 19'b0010000000000000000,
    S_POST = 19'b0100000000000000000,
    S_DONE = 19'b1000000000000000000
  } state_t;

  state_t state;
  task_status_t status;

  // configuration registers
  logic signed [23:0] goal_x, goal_y;
  logic signed [14:0] goal_heading;
  logic [15:0]        gain_rho, gain_alpha;
  logic signed [15:0] gain_beta;
  logic [22:0]        speed_limit;
  logic [31:0]        energy_per_metre;

  // pose and errors
  logic signed [23:0] px, py;
  logic signed [14:0] ph;
  logic signed [24:0] dx, dy;

  // shared multiplier, product registered
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;

  // square root
  logic [RAD_W-1:0]  sq_acc, rad;
  logic [26:0]       srem;
  logic [ROOT_W-1:0] root;
  logic [CNT_W-1:0]  cnt;

  // cordic
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic [IT_W-1:0]      it;
  logic                 sneg;

  // control law terms
  logic signed [14:0] alpha, beta;
  logic               flip;
  logic signed [23:0] v;
  logic signed [32:0] w_acc;
  logic signed [15:0] w;
  logic signed [32:0] cc, ss;

  // serial divider
  int_op_t           op;
  logic              tneg;
  logic [NUM_W-1:0]  num_sr;
  logic [REM_W-1:0]  drem, div_d;

  // step results
  logic signed [23:0] r_v, r_nx, r_ny;
  logic signed [15:0] r_w, r_nh;
  logic [31:0]        r_e;
  logic               r_moved;

  // input beat fields
  logic               in_cmd;
  logic signed [23:0] in_x, in_y;
  logic signed [14:0] in_h;

  assign in_cmd = s_tuser;
  assign in_x   = s_tdata[23:0];
  assign in_y   = s_tdata[47:24];
  assign in_h   = s_tdata[62:48];

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // combinational helpers
  // ---------------------------------------------------------------------------
  logic [28:0]          sq_sh, sq_trial;
  logic signed [CW-1:0] xsh, ysh;
  logic signed [ZW-1:0] at;
  logic signed [ZW-1:0] zr;
  logic signed [14:0]   gam_c, al0, be0, al1, be1, sa, sa2;
  logic                 flip_c, sneg_c;
  logic [23:0]          vabs;
  logic [28:0]          vraw;
  logic [22:0]          vcap;
  logic signed [33:0]   wsum, wsh;
  logic signed [67:0]   t_sel, t_abs;
  logic [45:0]          mag;
  logic [NUM_W-1:0]     num_c;
  logic [REM_W-1:0]     d_sel;
  logic [REM_W-1:0]     dsh;
  logic signed [57:0]   sq_q, sum_x, sum_y, sum_h;
  logic signed [CW-1:0] ax0, ay0;

  always_comb begin
    // square root digit: bring down two radicand bits
    sq_sh    = {srem, rad[RAD_W-1 -: 2]};
    sq_trial = {2'b00, root, 2'b01};

    // cordic shifts
    xsh = cx >>> it;
    ysh = cy >>> it;
    at  = atan_q20(5'(it));

    // atan2 start vector, scaled by 256
    ax0 = $signed({{3{dx[24]}}, dx, 8'b0});
    ay0 = $signed({{3{dy[24]}}, dy, 8'b0});

    // bearing and heading errors
    zr     = (cz + 25'sd128) >>> 8;
    gam_c  = wrap_q12(zr[17:0]);
    al0    = wrap_q12(sx15(gam_c) - sx15(ph));
    be0    = wrap_q12(sx15(goal_heading) - sx15(gam_c));
    flip_c = (sx15(al0) < -HALF_PI_Q12) || (sx15(al0) > HALF_PI_Q12);
    al1    = flip_c ? wrap_q12(sx15(al0) + PI_Q12) : al0;
    be1    = flip_c ? wrap_q12(sx15(be0) + PI_Q12) : be0;

    // sin/cos argument folded into the right half plane
    sa     = wrap_q12(sx15(ph));
    sa2    = sa;
    sneg_c = 1'b0;
    if (sx15(sa) > HALF_PI_Q12) begin
      sa2    = 15'(sx15(sa) - PI_Q12);
      sneg_c = 1'b1;
    end else if (sx15(sa) < -HALF_PI_Q12) begin
      sa2    = 15'(sx15(sa) + PI_Q12);
      sneg_c = 1'b1;
    end

    // speed
    vabs = v[23] ? 24'(-v) : 24'(v);
    vraw = prod[40:12];
    vcap = (vraw > {6'b0, speed_limit}) ? speed_limit : vraw[22:0];

    // turn rate
    wsum = $signed({w_acc[32], w_acc}) + $signed({prod[32], prod[32:0]}) + 34'sd2048;
    wsh  = wsum >>> 12;

    // divider operand
    unique case (op)
      OP_X, OP_Y: begin
        t_sel = prod >>> 18;
        d_sel = DIV_XY;
      end
      OP_H: begin
        t_sel = prod;
        d_sel = DIV_H;
      end
      OP_E: begin
        t_sel = prod >>> 10;
        d_sel = DIV_E;
      end
      default: begin
        t_sel = prod;
        d_sel = DIV_H;
      end
    endcase
    t_abs = t_sel[67] ? -t_sel : t_sel;
    mag   = t_abs[45:0];
    num_c = NUM_W'({10'b0, mag} * NUM_W'(TICK_MS)) + NUM_W'(d_sel >> 1);

    dsh = {drem[REM_W-2:0], num_sr[NUM_W-1]};

    // signed quotient and pose sums
    sq_q  = tneg ? -$signed({2'b00, num_sr}) : $signed({2'b00, num_sr});
    sum_x = $signed({{34{px[23]}}, px}) + sq_q;
    sum_y = $signed({{34{py[23]}}, py}) + sq_q;
    sum_h = $signed({{43{ph[14]}}, ph}) + sq_q;
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_SQX: begin
        ma = $signed({{9{dx[24]}}, dx});
        mb = $signed({{9{dx[24]}}, dx});
      end
      S_SQY: begin
        ma = $signed({{9{dy[24]}}, dy});
        mb = $signed({{9{dy[24]}}, dy});
      end
      S_VMUL: begin
        ma = $signed({18'b0, gain_rho});
        mb = $signed({9'b0, root});
      end
      S_VCAP: begin
        ma = $signed({18'b0, gain_alpha});
        mb = $signed({{19{alpha[14]}}, alpha});
      end
      S_W1: begin
        ma = $signed({{18{gain_beta[15]}}, gain_beta});
        mb = $signed({{19{beta[14]}}, beta});
      end
      S_MUL: begin
        unique case (op)
          OP_X: begin
            ma = $signed({{10{v[23]}}, v});
            mb = $signed({cc[32], cc});
          end
          OP_Y: begin
            ma = $signed({{10{v[23]}}, v});
            mb = $signed({ss[32], ss});
          end
          OP_H: begin
            ma = $signed({{18{w[15]}}, w});
            mb = 34'sd1;
          end
          OP_E: begin
            ma = $signed({10'b0, vabs});
            mb = $signed({2'b0, energy_per_metre});
          end
          default: begin
            ma = '0;
            mb = '0;
          end
        endcase
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x           <= '0;
      goal_y           <= '0;
      goal_heading     <= '0;
      gain_rho         <= '0;
      gain_alpha       <= '0;
      gain_beta        <= '0;
      speed_limit      <= 23'd4096;
      energy_per_metre <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GOAL_X:       goal_x           <= cfg_data[23:0];
        REG_GOAL_Y:       goal_y           <= cfg_data[23:0];
        REG_GOAL_HEADING: goal_heading     <= cfg_data[14:0];
        REG_GAIN_RHO:     gain_rho         <= cfg_data[15:0];
        REG_GAIN_ALPHA:   gain_alpha       <= cfg_data[15:0];
        REG_GAIN_BETA:    gain_beta        <= cfg_data[15:0];
        REG_SPEED_LIMIT:  speed_limit      <= cfg_data[22:0];
        REG_ENERGY:       energy_per_metre <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      status   <= TS_WAITING;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            r_v     <= '0;
            r_w     <= '0;
            r_nx    <= '0;
            r_ny    <= '0;
            r_nh    <= '0;
            r_e     <= '0;
            r_moved <= 1'b0;
            if (in_cmd == CMD_RESTART) begin
              status <= TS_WAITING;
              state  <= S_DONE;
            end else begin
              unique case (status)
                TS_WAITING: begin
                  status <= TS_RUNNING;
                  state  <= S_DONE;
                end
                TS_RUNNING: begin
                  px    <= in_x;
                  py    <= in_y;
                  ph    <= in_h;
                  dx    <= $signed({goal_x[23], goal_x}) - $signed({in_x[23], in_x});
                  dy    <= $signed({goal_y[23], goal_y}) - $signed({in_y[23], in_y});
                  state <= S_SQX;
                end
                default: state <= S_DONE;   // completed: stays put
              endcase
            end
          end
        end

        S_SQX: state <= S_SQY;

        S_SQY: begin
          sq_acc <= prod[RAD_W-1:0];
          state  <= S_SQS;
        end

        S_SQS: begin
          rad   <= sq_acc + prod[RAD_W-1:0];
          srem  <= '0;
          root  <= '0;
          cnt   <= '0;
          state <= S_SQRT;
        end

        // one root bit per cycle
        S_SQRT: begin
          if (sq_sh >= sq_trial) begin
            srem <= 27'(sq_sh - sq_trial);
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            srem <= sq_sh[26:0];
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          rad <= {rad[RAD_W-3:0], 2'b00};
          cnt <= cnt + 1'b1;
          if (cnt == SQRT_LAST) state <= S_NEAR;
        end

        S_NEAR: begin
          r_moved <= 1'b1;
          if (root <= NEAR_Q12) begin
            status <= TS_COMPLETED;
            r_nx   <= px;
            r_ny   <= py;
            r_nh   <= $signed({ph[14], ph});
            state  <= S_DONE;
          end else begin
            it <= '0;
            if (dx[24]) begin
              if (!dy[24]) begin
                cx <= ay0;
                cy <= -ax0;
                cz <= HALF_PI_Q20;
              end else begin
                cx <= -ay0;
                cy <= ax0;
                cz <= -HALF_PI_Q20;
              end
            end else begin
              cx <= ax0;
              cy <= ay0;
              cz <= '0;
            end
            state <= S_ATAN;
          end
        end

        // vectoring mode: drive y to zero
        S_ATAN: begin
          if (cy > 0) begin
            cx <= cx + ysh;
            cy <= cy - xsh;
            cz <= cz + at;
          end else begin
            cx <= cx - ysh;
            cy <= cy + xsh;
            cz <= cz - at;
          end
          it <= it + 1'b1;
          if (it == IT_LAST) state <= S_ANG;
        end

        S_ANG: begin
          alpha <= al1;
          beta  <= be1;
          flip  <= flip_c;
          // load rotation mode for sin/cos of the heading
          sneg  <= sneg_c;
          cx    <= CORDIC_INV_GAIN;
          cy    <= '0;
          cz    <= $signed({{2{sa2[14]}}, sa2, 8'b0});
          it    <= '0;
          state <= S_VMUL;
        end

        S_VMUL: state <= S_VCAP;

        S_VCAP: begin
          v     <= flip ? -$signed({1'b0, vcap}) : $signed({1'b0, vcap});
          r_v   <= flip ? -$signed({1'b0, vcap}) : $signed({1'b0, vcap});
          state <= S_W1;
        end

        S_W1: begin
          w_acc <= prod[32:0];
          state <= S_W2;
        end

        S_W2: begin
          if (wsh > 34'sd32767) begin
            w   <= 16'sh7FFF;
            r_w <= 16'sh7FFF;
          end else if (wsh < -34'sd32768) begin
            w   <= 16'sh8000;
            r_w <= 16'sh8000;
          end else begin
            w   <= wsh[15:0];
            r_w <= wsh[15:0];
          end
          state <= S_SIN;
        end

        // rotation mode: drive z to zero
        S_SIN: begin
          if (!cz[ZW-1]) begin
            cx <= cx - ysh;
            cy <= cy + xsh;
            cz <= cz - at;
          end else begin
            cx <= cx + ysh;
            cy <= cy - xsh;
            cz <= cz + at;
          end
          it <= it + 1'b1;
          if (it == IT_LAST) state <= S_SINF;
        end

        S_SINF: begin
          cc    <= sneg ? 33'(-cx) : 33'(cx);
          ss    <= sneg ? 33'(-cy) : 33'(cy);
          op    <= OP_X;
          state <= S_MUL;
        end

        S_MUL: state <= S_PREP;

        S_PREP: begin
          tneg   <= t_sel[67];
          num_sr <= num_c;
          drem   <= '0;
          div_d  <= d_sel;
          cnt    <= '0;
          state  <= S_DIV;
        end

        // restoring division, one quotient bit per cycle
        S_DIV: begin
          if (dsh >= div_d) begin
            drem   <= dsh - div_d;
            num_sr <= {num_sr[NUM_W-2:0], 1'b1};
          end else begin
            drem   <= dsh;
            num_sr <= {num_sr[NUM_W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) state <= S_POST;
        end

        S_POST: begin
          unique case (op)
            OP_X: begin
              r_nx  <= sat24(sum_x);
              op    <= OP_Y;
              state <= S_MUL;
            end
            OP_Y: begin
              r_ny  <= sat24(sum_y);
              op    <= OP_H;
              state <= S_MUL;
            end
            OP_H: begin
              r_nh  <= sat16(sum_h);
              op    <= OP_E;
              state <= S_MUL;
            end
            OP_E: begin
              r_e   <= (|num_sr[NUM_W-1:32]) ? 32'hFFFF_FFFF : num_sr[31:0];
              state <= S_DONE;
            end
            default: state <= S_DONE;
          endcase
        end

        // hand the result to the output register once it is free
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {6'b0, status, r_e, r_nh, r_ny, r_nx, r_w, r_v};
            m_tuser  <= r_moved;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
